/* sv/blc_pkg.sv */
// Shared codes and widths for the buffer cache tag and control store.
package blc_pkg;

  // Default number of buffer entries.
  localparam int unsigned NumBuffersDefault = 32;

  // Fixed field widths of the command and result ports.
  localparam int unsigned FuncW   = 2;
  localparam int unsigned DevW    = 8;
  localparam int unsigned BlkW    = 32;
  localparam int unsigned EntryW  = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 8;

  // Largest reference count an entry can hold.
  localparam logic [CountW-1:0] RefMax = {CountW{1'b1}};

  typedef enum logic [FuncW-1:0] {
    FuncRead    = 2'd0,
    FuncWrite   = 2'd1,
    FuncRelease = 2'd2,
    FuncBad     = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StNoFree   = 2'd1,
    StBadEnt   = 2'd2,
    StOverflow = 2'd3
  } status_e;

endpackage

/* sv/blc_cell.sv */
// One buffer entry: tag, valid, reference count and recency rank, plus one scan stage.
module blc_cell #(
  parameter int unsigned NumBuffers = blc_pkg::NumBuffersDefault,
  parameter int unsigned CellIdx    = 0,
  parameter int unsigned IdxW       = $clog2(NumBuffers)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [blc_pkg::DevW-1:0]    req_dev_i,
  input  logic [blc_pkg::BlkW-1:0]    req_blk_i,
  input  logic [blc_pkg::EntryW-1:0]  req_idx_i,
  input  logic [(1+2*IdxW+blc_pkg::CountW+1+1+2*IdxW+blc_pkg::CountW+IdxW
                 +blc_pkg::DevW+blc_pkg::BlkW)-1:0] tok_i,
  output logic [(1+2*IdxW+blc_pkg::CountW+1+1+2*IdxW+blc_pkg::CountW+IdxW
                 +blc_pkg::DevW+blc_pkg::BlkW)-1:0] tok_o,
  input  logic [(1+IdxW+6+IdxW)-1:0]  upd_i
);

  typedef struct packed {
    logic                       hit_found;
    logic [IdxW-1:0]            hit_idx;
    logic [IdxW-1:0]            hit_rank;
    logic [blc_pkg::CountW-1:0] hit_cnt;
    logic                       hit_valid;
    logic                       free_found;
    logic [IdxW-1:0]            free_idx;
    logic [IdxW-1:0]            free_rank;
    logic [blc_pkg::CountW-1:0] sel_cnt;
    logic [IdxW-1:0]            sel_rank;
    logic [blc_pkg::DevW-1:0]   sel_dev;
    logic [blc_pkg::BlkW-1:0]   sel_blk;
  } token_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] target;
    logic            set_tag;
    logic            set_valid;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            cnt_one;
    logic            promote;
    logic [IdxW-1:0] prom_rank;
  } upd_t;

  localparam logic [IdxW-1:0] MyIdx     = IdxW'(CellIdx);
  localparam logic [IdxW-1:0] RankReset = IdxW'(NumBuffers - 1 - CellIdx);

  logic [blc_pkg::DevW-1:0]   dev_q, dev_d;
  logic [blc_pkg::BlkW-1:0]   blk_q, blk_d;
  logic                       valid_q, valid_d;
  logic [blc_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]            rank_q, rank_d;
  token_t                     tok_q, tok_d, tok_in;
  upd_t                       upd;
  logic                       tag_eq;

  assign tok_in = token_t'(tok_i);
  assign upd    = upd_t'(upd_i);
  assign tok_o  = tok_q;
  assign tag_eq = (dev_q == req_dev_i) && (blk_q == req_blk_i);

  // Scan stage: fold this entry into the running search results.
  always_comb begin
    tok_d = tok_in;
    if (tag_eq && (!tok_in.hit_found || (rank_q < tok_in.hit_rank))) begin
      tok_d.hit_found = 1'b1;
      tok_d.hit_idx   = MyIdx;
      tok_d.hit_rank  = rank_q;
      tok_d.hit_cnt   = cnt_q;
      tok_d.hit_valid = valid_q;
    end
    if ((cnt_q == '0) && (!tok_in.free_found || (rank_q > tok_in.free_rank))) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = MyIdx;
      tok_d.free_rank  = rank_q;
    end
    if (32'(req_idx_i) == 32'(CellIdx)) begin
      tok_d.sel_cnt  = cnt_q;
      tok_d.sel_rank = rank_q;
      tok_d.sel_dev  = dev_q;
      tok_d.sel_blk  = blk_q;
    end
  end

  // Entry update, applied once per command after the scan has finished.
  always_comb begin
    dev_d   = dev_q;
    blk_d   = blk_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    if (upd.en) begin
      if (upd.target == MyIdx) begin
        if (upd.set_tag) begin
          dev_d = req_dev_i;
          blk_d = req_blk_i;
        end
        if (upd.set_valid) valid_d = 1'b1;
        if (upd.cnt_inc)   cnt_d   = cnt_q + 1'b1;
        if (upd.cnt_dec)   cnt_d   = cnt_q - 1'b1;
        if (upd.cnt_one)   cnt_d   = blc_pkg::CountW'(1);
        if (upd.promote)   rank_d  = '0;
      end else if (upd.promote && (rank_q < upd.prom_rank)) begin
        rank_d = rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q   <= '0;
      blk_q   <= '0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      rank_q  <= RankReset;
      tok_q   <= '0;
    end else begin
      dev_q   <= dev_d;
      blk_q   <= blk_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      rank_q  <= rank_d;
      tok_q   <= tok_d;
    end
  end

endmodule

/* sv/block_buffer_cache_lru_unit.sv */
// Top level of the buffer cache tag and control store: command sequencer and cell chain.
//
//   Channel   Direction  Handshake                 Payload
//   command   in         start_i high, busy_o low  func_i, device_i, block_number_i,
//                                                  entry_index_i
//   result    out        done_o strobe, one cycle  result_index_o, was_hit_o,
//                                                  disk_read_request_o, disk_write_request_o,
//                                                  disk_device_o, disk_block_o, status_o
//
// The result strobe of a command follows the scan of the whole chain and the finishing
// state, and the next command can be transferred in the cycle the strobe is high, so
// a new command is taken only once the last is through. The spacing is set by the
// search token, which walks the cell chain one entry per cycle.
// Reset is asynchronous and active low; it returns every entry to tag zero, invalid,
// unreferenced, with entry i at rank NumBuffers-1-i.
// busy_o stays high from a command transfer until its result is registered. The result
// is shown for exactly one cycle and the receiver cannot stall it.
module block_buffer_cache_lru_unit #(
  parameter int unsigned NumBuffers = blc_pkg::NumBuffersDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [blc_pkg::FuncW-1:0]    func_i,
  input  logic [blc_pkg::DevW-1:0]     device_i,
  input  logic [blc_pkg::BlkW-1:0]     block_number_i,
  input  logic [blc_pkg::EntryW-1:0]   entry_index_i,
  output logic                         done_o,
  output logic [blc_pkg::EntryW-1:0]   result_index_o,
  output logic                         was_hit_o,
  output logic                         disk_read_request_o,
  output logic                         disk_write_request_o,
  output logic [blc_pkg::DevW-1:0]     disk_device_o,
  output logic [blc_pkg::BlkW-1:0]     disk_block_o,
  output logic [blc_pkg::StatusW-1:0]  status_o
);

  localparam int unsigned IdxW = $clog2(NumBuffers);
  localparam logic [IdxW-1:0] LastCell = IdxW'(NumBuffers - 1);

  // The search token carried along the chain. Each cell keeps the best hit seen so far
  // (lowest rank among matching tags), the best victim (highest rank among entries with
  // no references) and a copy of the entry named by entry_index.
  typedef struct packed {
    logic                       hit_found;
    logic [IdxW-1:0]            hit_idx;
    logic [IdxW-1:0]            hit_rank;
    logic [blc_pkg::CountW-1:0] hit_cnt;
    logic                       hit_valid;
    logic                       free_found;
    logic [IdxW-1:0]            free_idx;
    logic [IdxW-1:0]            free_rank;
    logic [blc_pkg::CountW-1:0] sel_cnt;
    logic [IdxW-1:0]            sel_rank;
    logic [blc_pkg::DevW-1:0]   sel_dev;
    logic [blc_pkg::BlkW-1:0]   sel_blk;
  } token_t;

  // The update command broadcast to all cells in the finishing cycle.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] target;
    logic            set_tag;
    logic            set_valid;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            cnt_one;
    logic            promote;
    logic [IdxW-1:0] prom_rank;
  } upd_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StFin  = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [IdxW-1:0]               step_q, step_d;
  logic [blc_pkg::FuncW-1:0]     func_q;
  logic [blc_pkg::DevW-1:0]      dev_q;
  logic [blc_pkg::BlkW-1:0]      blk_q;
  logic [blc_pkg::EntryW-1:0]    idx_q;
  token_t                        tok [NumBuffers];
  token_t                        tok_last;
  upd_t                          upd;
  logic                          accept;

  // Result registers.
  logic                          done_q;
  logic [blc_pkg::EntryW-1:0]    res_idx_q, res_idx_d;
  logic                          hit_q, hit_d;
  logic                          rd_q, rd_d;
  logic                          wr_q, wr_d;
  logic [blc_pkg::DevW-1:0]      ddev_q, ddev_d;
  logic [blc_pkg::BlkW-1:0]      dblk_q, dblk_d;
  blc_pkg::status_e              st_q, st_d;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  // The cell chain. Cell 0 starts from an empty token; every cell hands its token on
  // to its neighbor each cycle, so the full answer leaves the last cell when the scan ends.
  for (genvar g = 0; g < NumBuffers; g++) begin : g_cell
    blc_cell #(
      .NumBuffers (NumBuffers),
      .CellIdx    (g),
      .IdxW       (IdxW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .req_dev_i (dev_q),
      .req_blk_i (blk_q),
      .req_idx_i (idx_q),
      .tok_i     ((g == 0) ? token_t'('0) : tok[(g == 0) ? 0 : g - 1]),
      .tok_o     (tok[g]),
      .upd_i     (upd)
    );
  end

  assign tok_last = tok[NumBuffers-1];

  // Sequencer: idle, scan the chain, then apply the update and register the result.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StScan;
          step_d  = '0;
        end
      end
      StScan: begin
        step_d = step_q + 1'b1;
        if (step_q == LastCell) state_d = StFin;
      end
      StFin: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Decision made from the finished token. A write or release naming an entry beyond
  // the last cell finds no cell, so its count reads as zero and it is rejected.
  always_comb begin
    upd       = '0;
    res_idx_d = '0;
    hit_d     = 1'b0;
    rd_d      = 1'b0;
    wr_d      = 1'b0;
    ddev_d    = '0;
    dblk_d    = '0;
    st_d      = blc_pkg::StOk;
    unique case (blc_pkg::func_e'(func_q))
      blc_pkg::FuncRead: begin
        if (tok_last.hit_found) begin
          res_idx_d = blc_pkg::EntryW'(tok_last.hit_idx);
          hit_d     = 1'b1;
          if (tok_last.hit_cnt == blc_pkg::RefMax) begin
            st_d = blc_pkg::StOverflow;
          end else begin
            upd.en      = 1'b1;
            upd.target  = tok_last.hit_idx;
            upd.cnt_inc = 1'b1;
            if (!tok_last.hit_valid) begin
              upd.set_valid = 1'b1;
              rd_d          = 1'b1;
              ddev_d        = dev_q;
              dblk_d        = blk_q;
            end
          end
        end else if (tok_last.free_found) begin
          // Retagging leaves the entry empty, so a fill from disk is always requested.
          upd.en        = 1'b1;
          upd.target    = tok_last.free_idx;
          upd.set_tag   = 1'b1;
          upd.set_valid = 1'b1;
          upd.cnt_one   = 1'b1;
          res_idx_d     = blc_pkg::EntryW'(tok_last.free_idx);
          rd_d          = 1'b1;
          ddev_d        = dev_q;
          dblk_d        = blk_q;
        end else begin
          st_d = blc_pkg::StNoFree;
        end
      end
      blc_pkg::FuncWrite: begin
        res_idx_d = idx_q;
        if (tok_last.sel_cnt == '0) begin
          st_d = blc_pkg::StBadEnt;
        end else begin
          wr_d   = 1'b1;
          ddev_d = tok_last.sel_dev;
          dblk_d = tok_last.sel_blk;
        end
      end
      blc_pkg::FuncRelease: begin
        res_idx_d = idx_q;
        if (tok_last.sel_cnt == '0) begin
          st_d = blc_pkg::StBadEnt;
        end else begin
          // Dropping the last reference makes the entry the most recent one.
          upd.en        = 1'b1;
          upd.target    = IdxW'(idx_q);
          upd.cnt_dec   = 1'b1;
          upd.promote   = (tok_last.sel_cnt == blc_pkg::CountW'(1));
          upd.prom_rank = tok_last.sel_rank;
        end
      end
      default: begin
        res_idx_d = idx_q;
        st_d      = blc_pkg::StBadEnt;
      end
    endcase
    if (state_q != StFin) upd.en = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= (state_q == StFin);
    end
  end

  // Command and result payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      dev_q  <= device_i;
      blk_q  <= block_number_i;
      idx_q  <= entry_index_i;
    end
    if (state_q == StFin) begin
      res_idx_q <= res_idx_d;
      hit_q     <= hit_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      ddev_q    <= ddev_d;
      dblk_q    <= dblk_d;
      st_q      <= st_d;
    end
  end

  assign done_o               = done_q;
  assign result_index_o       = res_idx_q;
  assign was_hit_o            = hit_q;
  assign disk_read_request_o  = rd_q;
  assign disk_write_request_o = wr_q;
  assign disk_device_o        = ddev_q;
  assign disk_block_o         = dblk_q;
  assign status_o             = st_q;

  // A transfer always starts a scan.
  a_accept_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StScan) && (step_q == '0))
    else $error("command transfer did not start a scan");

  // A result strobe follows only the finishing cycle, and the unit is idle then.
  a_done_after_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == StFin) && !busy_o)
    else $error("result strobe without a finished command");

  // A result never asks for a disk read and a disk write at once.
  a_one_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(disk_read_request_o && disk_write_request_o))
    else $error("disk read and write requested together");

  // Exhaustion reports entry zero and raises no disk request.
  a_nofree_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == blc_pkg::StNoFree)) |->
      (result_index_o == '0) && !disk_read_request_o && !was_hit_o)
    else $error("exhaustion result carries a grant");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the buffer cache tag and control store.
`timescale 1ns / 1ps

module tb;

  localparam int NB = blc_pkg::NumBuffersDefault;
  // The quiet time at the end is long enough to cover one more command with margin.
  localparam int SettleCycles = NB + 8;
  // The limit is several times what about 1450 commands, plus short sender gaps, take.
  localparam int CycleLimit = 400000;
  localparam int TagPoolSize = 40;

  // One result as it appears on the result ports.
  typedef struct packed {
    logic [blc_pkg::EntryW-1:0]  idx;
    logic                        hit;
    logic                        rd;
    logic                        wr;
    logic [blc_pkg::DevW-1:0]    dev;
    logic [blc_pkg::BlkW-1:0]    blk;
    blc_pkg::status_e            st;
  } cache_result_t;

  // One row of the directed table. Where typed is set, want is the result to expect;
  // otherwise the result comes from the cache model.
  typedef struct packed {
    blc_pkg::func_e              f;
    logic [blc_pkg::DevW-1:0]    dev;
    logic [blc_pkg::BlkW-1:0]    blk;
    logic [blc_pkg::EntryW-1:0]  idx;
    bit                          typed;
    cache_result_t               want;
  } dir_row_t;

  localparam cache_result_t NoCheck = '0;

  localparam int DirN = 20;
  localparam dir_row_t DirTable [DirN] = '{
    // Every entry is tagged device 0 block 0 after reset, so this read hits. The
    // entry with the lowest rank is the last one, and it is not valid yet.
    '{blc_pkg::FuncRead, 8'h00, 32'h0000_0000, 5'd0, 1'b1,
      '{5'd31, 1'b1, 1'b1, 1'b0, 8'h00, 32'h0000_0000, blc_pkg::StOk}},
    '{blc_pkg::FuncRead, 8'h00, 32'h0000_0000, 5'd0, 1'b0, NoCheck},
    // A miss with all-ones tag takes the least recent free entry, entry 0.
    '{blc_pkg::FuncRead, 8'hff, 32'hffff_ffff, 5'd0, 1'b1,
      '{5'd0, 1'b0, 1'b1, 1'b0, 8'hff, 32'hffff_ffff, blc_pkg::StOk}},
    '{blc_pkg::FuncWrite, 8'h00, 32'h0000_0000, 5'd0, 1'b1,
      '{5'd0, 1'b0, 1'b0, 1'b1, 8'hff, 32'hffff_ffff, blc_pkg::StOk}},
    '{blc_pkg::FuncWrite, 8'hff, 32'hffff_ffff, 5'd31, 1'b1,
      '{5'd31, 1'b0, 1'b0, 1'b1, 8'h00, 32'h0000_0000, blc_pkg::StOk}},
    // Release of an entry nobody holds.
    '{blc_pkg::FuncRelease, 8'h00, 32'h0000_0000, 5'd5, 1'b1,
      '{5'd5, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000, blc_pkg::StBadEnt}},
    // The unknown function code is refused even on a held entry.
    '{blc_pkg::FuncBad, 8'hff, 32'hffff_ffff, 5'd31, 1'b1,
      '{5'd31, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000, blc_pkg::StBadEnt}},
    // Write back of an entry nobody holds.
    '{blc_pkg::FuncWrite, 8'h00, 32'h0000_0000, 5'd17, 1'b1,
      '{5'd17, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000, blc_pkg::StBadEnt}},
    '{blc_pkg::FuncRelease, 8'h00, 32'h0000_0000, 5'd0, 1'b1,
      '{5'd0, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000, blc_pkg::StOk}},
    // Entry 0 is free but still valid, so the read hits it without a disk read.
    '{blc_pkg::FuncRead, 8'hff, 32'hffff_ffff, 5'd0, 1'b1,
      '{5'd0, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0000_0000, blc_pkg::StOk}},
    '{blc_pkg::FuncRead, 8'haa, 32'h5555_5555, 5'd0, 1'b0, NoCheck},
    '{blc_pkg::FuncRead, 8'h55, 32'haaaa_aaaa, 5'd0, 1'b0, NoCheck},
    '{blc_pkg::FuncRelease, 8'h00, 32'h0000_0000, 5'd31, 1'b0, NoCheck},
    '{blc_pkg::FuncRelease, 8'h00, 32'h0000_0000, 5'd31, 1'b0, NoCheck},
    '{blc_pkg::FuncRelease, 8'h00, 32'h0000_0000, 5'd31, 1'b1,
      '{5'd31, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000, blc_pkg::StBadEnt}},
    '{blc_pkg::FuncRead, 8'h00, 32'h0000_0000, 5'd0, 1'b0, NoCheck},
    '{blc_pkg::FuncRelease, 8'h00, 32'h0000_0000, 5'd0, 1'b0, NoCheck},
    '{blc_pkg::FuncWrite, 8'h00, 32'h0000_0000, 5'd1, 1'b0, NoCheck},
    '{blc_pkg::FuncRead, 8'h01, 32'h0000_0001, 5'd0, 1'b0, NoCheck},
    '{blc_pkg::FuncRelease, 8'h00, 32'h0000_0000, 5'd1, 1'b0, NoCheck}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [blc_pkg::FuncW-1:0]    func_i;
  logic [blc_pkg::DevW-1:0]     device_i;
  logic [blc_pkg::BlkW-1:0]     block_number_i;
  logic [blc_pkg::EntryW-1:0]   entry_index_i;
  logic                         done_o;
  logic [blc_pkg::EntryW-1:0]   result_index_o;
  logic                         was_hit_o;
  logic                         disk_read_request_o;
  logic                         disk_write_request_o;
  logic [blc_pkg::DevW-1:0]     disk_device_o;
  logic [blc_pkg::BlkW-1:0]     disk_block_o;
  logic [blc_pkg::StatusW-1:0]  status_o;

  block_buffer_cache_lru_unit #(
    .NumBuffers(NB)
  ) u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .func_i,
    .device_i,
    .block_number_i,
    .entry_index_i,
    .done_o,
    .result_index_o,
    .was_hit_o,
    .disk_read_request_o,
    .disk_write_request_o,
    .disk_device_o,
    .disk_block_o,
    .status_o
  );

  // Cache model state: one copy of every entry's tag, valid bit, count and rank.
  logic [blc_pkg::DevW-1:0]    cm_dev   [NB];
  logic [blc_pkg::BlkW-1:0]    cm_blk   [NB];
  bit                          cm_valid [NB];
  logic [blc_pkg::CountW-1:0]  cm_refs  [NB];
  int                          cm_rank  [NB];

  // Results that the block still owes, oldest first.
  cache_result_t pending_results[$];

  int  err_count;
  int  cycle_count;
  bit  idle_en;

  logic [blc_pkg::DevW-1:0]  pool_dev [TagPoolSize];
  logic [blc_pkg::BlkW-1:0]  pool_blk [TagPoolSize];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic reset_cache_model();
    for (int i = 0; i < NB; i++) begin
      cm_dev[i]   = '0;
      cm_blk[i]   = '0;
      cm_valid[i] = 1'b0;
      cm_refs[i]  = '0;
      cm_rank[i]  = NB - 1 - i;
    end
  endtask

  // Applies one command to the cache model and returns the result it must produce.
  function automatic cache_result_t apply_cache_cmd(blc_pkg::func_e f,
                                                    logic [blc_pkg::DevW-1:0] dev,
                                                    logic [blc_pkg::BlkW-1:0] blk,
                                                    logic [blc_pkg::EntryW-1:0] idx);
    cache_result_t r;
    int found;
    int best;
    int old_rank;
    r = '0;
    r.st = blc_pkg::StOk;
    if (f == blc_pkg::FuncRead) begin
      // A hit goes to the most recent entry that carries the tag.
      found = -1;
      best = 0;
      for (int i = 0; i < NB; i++) begin
        if (cm_dev[i] == dev && cm_blk[i] == blk && (found < 0 || cm_rank[i] < best)) begin
          found = i;
          best = cm_rank[i];
        end
      end
      if (found >= 0) begin
        r.hit = 1'b1;
        if (cm_refs[found] == blc_pkg::RefMax) begin
          r.idx = blc_pkg::EntryW'(found);
          r.st = blc_pkg::StOverflow;
          return r;
        end
        cm_refs[found] = cm_refs[found] + 1'b1;
      end else begin
        // A miss evicts the least recent entry that nobody holds.
        for (int i = 0; i < NB; i++) begin
          if (cm_refs[i] == 0 && (found < 0 || cm_rank[i] > best)) begin
            found = i;
            best = cm_rank[i];
          end
        end
        if (found < 0) begin
          r.st = blc_pkg::StNoFree;
          return r;
        end
        cm_dev[found]   = dev;
        cm_blk[found]   = blk;
        cm_valid[found] = 1'b0;
        cm_refs[found]  = blc_pkg::CountW'(1);
      end
      r.idx = blc_pkg::EntryW'(found);
      if (!cm_valid[found]) begin
        cm_valid[found] = 1'b1;
        r.rd  = 1'b1;
        r.dev = dev;
        r.blk = blk;
      end
      return r;
    end
    r.idx = idx;
    if (f == blc_pkg::FuncBad || int'(idx) >= NB || cm_refs[idx] == 0) begin
      r.st = blc_pkg::StBadEnt;
      return r;
    end
    if (f == blc_pkg::FuncWrite) begin
      r.wr  = 1'b1;
      r.dev = cm_dev[idx];
      r.blk = cm_blk[idx];
      return r;
    end
    cm_refs[idx] = cm_refs[idx] - 1'b1;
    if (cm_refs[idx] == 0) begin
      // The freed entry becomes the most recent; the ones above it age by one.
      old_rank = cm_rank[idx];
      for (int i = 0; i < NB; i++) begin
        if (cm_rank[i] < old_rank) cm_rank[i]++;
      end
      cm_rank[idx] = 0;
    end
    return r;
  endfunction

  // Picks an entry that is currently held, or a random one when none is held.
  function automatic logic [blc_pkg::EntryW-1:0] pick_held_entry();
    int held[$];
    for (int i = 0; i < NB; i++) begin
      if (cm_refs[i] != 0) held.push_back(i);
    end
    if (held.size() == 0) return blc_pkg::EntryW'($urandom_range(NB - 1));
    return blc_pkg::EntryW'(held[$urandom_range(held.size() - 1)]);
  endfunction

  task automatic report_mismatch(string what, logic [blc_pkg::BlkW-1:0] got,
                                 logic [blc_pkg::BlkW-1:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  // Presents one command and returns once it has been transferred. The sender may
  // first sit idle for a while, with junk on the command fields and start_i low.
  task automatic send_cmd(blc_pkg::func_e f, logic [blc_pkg::DevW-1:0] dev,
                          logic [blc_pkg::BlkW-1:0] blk,
                          logic [blc_pkg::EntryW-1:0] idx, bit typed, cache_result_t want,
                          output cache_result_t modeled);
    int gap;
    gap = 0;
    while (idle_en && ($urandom_range(99) < 27)) gap++;
    // Only cycles in which the block is free count toward the gap, so every idle cycle
    // is one in which a transfer could have happened.
    while (gap > 0) begin
      start_i        <= 1'b0;
      func_i         <= blc_pkg::FuncW'($urandom);
      device_i       <= blc_pkg::DevW'($urandom);
      block_number_i <= $urandom;
      entry_index_i  <= blc_pkg::EntryW'($urandom);
      @(posedge clk_i);
      if (busy_o === 1'b0) gap--;
    end
    start_i        <= 1'b1;
    func_i         <= f;
    device_i       <= dev;
    block_number_i <= blk;
    entry_index_i  <= idx;
    // The transfer happens at the first edge that sees busy_o low.
    do @(posedge clk_i); while (busy_o !== 1'b0);
    modeled = apply_cache_cmd(f, dev, blk, idx);
    pending_results.push_back(typed ? want : modeled);
  endtask

  // Drops start_i and holds off until every owed result has come back.
  task automatic wait_results_drained();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: every strobe must match the oldest owed result, field by field.
  always @(posedge clk_i) begin : result_check
    cache_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing owed", blc_pkg::BlkW'(result_index_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (result_index_o !== want.idx)
          report_mismatch("result_index", blc_pkg::BlkW'(result_index_o),
                          blc_pkg::BlkW'(want.idx));
        if (was_hit_o !== want.hit)
          report_mismatch("was_hit", blc_pkg::BlkW'(was_hit_o), blc_pkg::BlkW'(want.hit));
        if (disk_read_request_o !== want.rd)
          report_mismatch("disk_read_request", blc_pkg::BlkW'(disk_read_request_o),
                          blc_pkg::BlkW'(want.rd));
        if (disk_write_request_o !== want.wr)
          report_mismatch("disk_write_request", blc_pkg::BlkW'(disk_write_request_o),
                          blc_pkg::BlkW'(want.wr));
        if (disk_device_o !== want.dev)
          report_mismatch("disk_device", blc_pkg::BlkW'(disk_device_o),
                          blc_pkg::BlkW'(want.dev));
        if (disk_block_o !== want.blk)
          report_mismatch("disk_block", disk_block_o, want.blk);
        if (status_o !== want.st)
          report_mismatch("status", blc_pkg::BlkW'(status_o), blc_pkg::BlkW'(want.st));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    cache_result_t modeled;
    blc_pkg::func_e f;
    logic [blc_pkg::DevW-1:0] dev;
    logic [blc_pkg::BlkW-1:0] blk;
    logic [blc_pkg::EntryW-1:0] idx;
    logic [blc_pkg::DevW-1:0] hot_dev;
    logic [blc_pkg::BlkW-1:0] hot_blk;
    logic [blc_pkg::EntryW-1:0] hot_idx;
    int rel_pct;
    int roll;
    int sel;
    int reads;
    int hot_entry;

    err_count      = 0;
    cycle_count    = 0;
    idle_en        = 1'b1;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    func_i         = '0;
    device_i       = '0;
    block_number_i = '0;
    entry_index_i  = '0;
    reset_cache_model();

    // Tag pool for the random part. It is a little larger than the cache, so reads
    // both hit and evict. The reset tag is in it, so the duplicates left by reset
    // keep being exercised.
    pool_dev[0] = '0;
    pool_blk[0] = '0;
    for (int i = 1; i < TagPoolSize; i++) begin
      pool_dev[i] = blc_pkg::DevW'($urandom);
      pool_blk[i] = $urandom;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset tags, the extremes of the tag fields, every function code
    // and the refused cases.
    for (int r = 0; r < DirN; r++) begin
      send_cmd(DirTable[r].f, DirTable[r].dev, DirTable[r].blk, DirTable[r].idx,
               DirTable[r].typed, DirTable[r].want, modeled);
    end

    // Random part, in blocks of 100 commands. Each block picks how often entries are
    // released: a low rate fills the cache until reads run out of free entries, a high
    // rate keeps entries cycling through the recency order. Blocks 3 and 4 run with
    // the sender never idle.
    for (int b = 0; b < 9; b++) begin
      idle_en = !(b == 3 || b == 4);
      case ($urandom_range(2))
        0: rel_pct = 15;
        1: rel_pct = 35;
        default: rel_pct = 50;
      endcase
      for (int k = 0; k < 100; k++) begin
        roll = $urandom_range(99);
        if (roll < rel_pct) f = blc_pkg::FuncRelease;
        else if (roll < rel_pct + 10) f = blc_pkg::FuncWrite;
        else if (roll < rel_pct + 15) f = blc_pkg::FuncBad;
        else f = blc_pkg::FuncRead;
        sel = $urandom_range(TagPoolSize + 9);
        if (sel < TagPoolSize) begin
          dev = pool_dev[sel];
          blk = pool_blk[sel];
        end else begin
          dev = blc_pkg::DevW'($urandom);
          blk = $urandom;
        end
        idx = ($urandom_range(99) < 80) ? pick_held_entry()
                                        : blc_pkg::EntryW'($urandom);
        send_cmd(f, dev, blk, idx, 1'b0, NoCheck, modeled);
      end

      // Let the block run dry once, so a command arrives to a fully idle unit.
      if (b == 2) wait_results_drained();

      // Count overflow: keep reading the tag of one entry until its count saturates,
      // then release it all the way back to zero.
      if (b == 5) begin
        hot_entry = $urandom_range(NB - 1);
        hot_dev = cm_dev[hot_entry];
        hot_blk = cm_blk[hot_entry];
        reads = 0;
        do begin
          send_cmd(blc_pkg::FuncRead, hot_dev, hot_blk, blc_pkg::EntryW'($urandom), 1'b0,
                   NoCheck, modeled);
          reads++;
        end while (modeled.st != blc_pkg::StOverflow && reads < 300);
        hot_idx = modeled.idx;
        while (cm_refs[hot_idx] != 0) begin
          send_cmd(blc_pkg::FuncRelease, blc_pkg::DevW'($urandom), $urandom, hot_idx,
                   1'b0, NoCheck, modeled);
        end
      end
    end

    // Wind down: stop sending, collect every owed result, then watch for strays.
    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
